// File: design/pac_pkg.sv
// shared types and constants for the popup alpha compositor
`timescale 1ns / 1ps

package pac_pkg;

  localparam int MAX_DIM_DEFAULT = 4096;

  localparam int CHAN_W      = 8;
  localparam int SIZE_W      = 13;
  localparam int POS_W       = 16;
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_WIDTH   = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] REG_VIEW_HEIGHT  = CFG_INDEX_W'(1);
  localparam logic [CFG_INDEX_W-1:0] REG_POPUP_WIDTH  = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] REG_POPUP_HEIGHT = CFG_INDEX_W'(3);
  localparam logic [CFG_INDEX_W-1:0] REG_POPUP_X      = CFG_INDEX_W'(4);
  localparam logic [CFG_INDEX_W-1:0] REG_POPUP_Y      = CFG_INDEX_W'(5);
  localparam logic [CFG_INDEX_W-1:0] REG_POPUP_ENABLE = CFG_INDEX_W'(6);

  localparam logic [CHAN_W-1:0] CHAN_MAX   = 8'd255;
  localparam logic [CHAN_W-1:0] ROUND_BIAS = 8'd127;

  typedef struct packed {
    logic [CHAN_W-1:0] view_blue;
    logic [CHAN_W-1:0] view_green;
    logic [CHAN_W-1:0] view_red;
    logic [CHAN_W-1:0] view_alpha;
    logic [CHAN_W-1:0] popup_blue;
    logic [CHAN_W-1:0] popup_green;
    logic [CHAN_W-1:0] popup_red;
    logic [CHAN_W-1:0] popup_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [CHAN_W-1:0] out_blue;
    logic [CHAN_W-1:0] out_green;
    logic [CHAN_W-1:0] out_red;
    logic [CHAN_W-1:0] out_alpha;
    logic              in_popup;
    logic              frame_last;
  } pixel_out_t;

endpackage

// File: design/pac_geom.sv
// configuration registers and registered popup rectangle
`timescale 1ns / 1ps

module pac_geom #(
  parameter int MAX_DIM = pac_pkg::MAX_DIM_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write_enable,
  input  logic [pac_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]      cfg_data,
  output logic [$clog2(MAX_DIM+1)-1:0]        view_w,
  output logic [$clog2(MAX_DIM+1)-1:0]        view_h,
  output logic [$clog2(MAX_DIM+1)-1:0]        rect_x0,
  output logic [$clog2(MAX_DIM+1)-1:0]        rect_x1,
  output logic [$clog2(MAX_DIM+1)-1:0]        rect_y0,
  output logic [$clog2(MAX_DIM+1)-1:0]        rect_y1,
  output logic                                active
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int GA = (DW > pac_pkg::POS_W) ? DW : pac_pkg::POS_W;
  localparam int GW = ((GA > pac_pkg::SIZE_W) ? GA : pac_pkg::SIZE_W) + 1;
  localparam logic [GW-1:0] MAX_G = GW'(MAX_DIM);

  logic [pac_pkg::SIZE_W-1:0]       view_cols;
  logic [pac_pkg::SIZE_W-1:0]       view_rows;
  logic [pac_pkg::SIZE_W-1:0]       popup_cols;
  logic [pac_pkg::SIZE_W-1:0]       popup_rows;
  logic signed [pac_pkg::POS_W-1:0] popup_x;
  logic signed [pac_pkg::POS_W-1:0] popup_y;
  logic                             popup_enable;

  logic [GW-1:0] w_g;
  logic [GW-1:0] h_g;
  logic [GW-1:0] x0_g;
  logic [GW-1:0] y0_g;
  logic [GW-1:0] x1_g;
  logic [GW-1:0] y1_g;
  logic          active_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      view_cols    <= '0;
      view_rows    <= '0;
      popup_cols   <= '0;
      popup_rows   <= '0;
      popup_x      <= '0;
      popup_y      <= '0;
      popup_enable <= 1'b0;
    end else if (cfg_write_enable) begin
      case (cfg_index)
        pac_pkg::REG_VIEW_WIDTH:   view_cols    <= cfg_data[pac_pkg::SIZE_W-1:0];
        pac_pkg::REG_VIEW_HEIGHT:  view_rows    <= cfg_data[pac_pkg::SIZE_W-1:0];
        pac_pkg::REG_POPUP_WIDTH:  popup_cols   <= cfg_data[pac_pkg::SIZE_W-1:0];
        pac_pkg::REG_POPUP_HEIGHT: popup_rows   <= cfg_data[pac_pkg::SIZE_W-1:0];
        pac_pkg::REG_POPUP_X:      popup_x      <= cfg_data[pac_pkg::POS_W-1:0];
        pac_pkg::REG_POPUP_Y:      popup_y      <= cfg_data[pac_pkg::POS_W-1:0];
        pac_pkg::REG_POPUP_ENABLE: popup_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // clamp origin into the view, pull it back if the popup overhangs
  function automatic logic [GW-1:0] fit_origin(
    input logic signed [pac_pkg::POS_W-1:0] req,
    input logic [GW-1:0]                    psize,
    input logic [GW-1:0]                    vsize
  );
    logic [GW-1:0] p;
    p = req[pac_pkg::POS_W-1] ? '0 : GW'($unsigned(req));
    if (p + psize > vsize) begin
      p = (psize >= vsize) ? '0 : vsize - psize;
    end
    return p;
  endfunction

  always_comb begin
    w_g  = (GW'(view_cols) > MAX_G) ? MAX_G : GW'(view_cols);
    h_g  = (GW'(view_rows) > MAX_G) ? MAX_G : GW'(view_rows);
    x0_g = fit_origin(popup_x, GW'(popup_cols), w_g);
    y0_g = fit_origin(popup_y, GW'(popup_rows), h_g);
    x1_g = (x0_g + GW'(popup_cols) > w_g) ? w_g : x0_g + GW'(popup_cols);
    y1_g = (y0_g + GW'(popup_rows) > h_g) ? h_g : y0_g + GW'(popup_rows);
    active_next = (w_g != '0) && (h_g != '0) && popup_enable &&
                  (popup_cols != '0) && (popup_rows != '0);
  end

  assign view_w = w_g[DW-1:0];
  assign view_h = h_g[DW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else begin
      active <= active_next;
    end
  end

  // bounds only matter while active, where they all lie within the view
  always_ff @(posedge clk) begin
    rect_x0 <= x0_g[DW-1:0];
    rect_x1 <= x1_g[DW-1:0];
    rect_y0 <= y0_g[DW-1:0];
    rect_y1 <= y1_g[DW-1:0];
  end

endmodule

// File: design/pac_raster.sv
// column and row counters for the raster scan
`timescale 1ns / 1ps

module pac_raster #(
  parameter int MAX_DIM = pac_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            advance,
  input  logic [$clog2(MAX_DIM+1)-1:0]    view_w,
  input  logic [$clog2(MAX_DIM+1)-1:0]    view_h,
  output logic [$clog2(MAX_DIM)-1:0]      column,
  output logic [$clog2(MAX_DIM)-1:0]      row,
  output logic                            frame_last
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);

  logic          view_ok;
  logic          row_end;
  logic          row_final;
  logic [DW-1:0] column_inc;
  logic [DW-1:0] row_inc;
  logic [CW-1:0] column_next;
  logic [CW-1:0] row_next;

  always_comb begin
    view_ok    = (view_w != '0) && (view_h != '0);
    column_inc = DW'(column) + DW'(1);
    row_inc    = DW'(row) + DW'(1);
    // at or past the edge ends the line, also after a size change
    row_end    = column_inc >= view_w;
    row_final  = row_inc >= view_h;
    frame_last = view_ok && row_end && row_final;

    column_next = column;
    row_next    = row;
    if (view_ok) begin
      if (row_end) begin
        column_next = '0;
        row_next    = row_final ? '0 : row_inc[CW-1:0];
      end else begin
        column_next = column_inc[CW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      column <= '0;
      row    <= '0;
    end else if (advance) begin
      column <= column_next;
      row    <= row_next;
    end
  end

endmodule

// File: design/pac_pixel.sv
// rectangle test and premultiplied source-over blend for one pixel
`timescale 1ns / 1ps

module pac_pixel #(
  parameter int MAX_DIM = pac_pkg::MAX_DIM_DEFAULT
) (
  input  pac_pkg::pixel_in_t              pix,
  input  logic [$clog2(MAX_DIM)-1:0]      column,
  input  logic [$clog2(MAX_DIM)-1:0]      row,
  input  logic                            last,
  input  logic [$clog2(MAX_DIM+1)-1:0]    rect_x0,
  input  logic [$clog2(MAX_DIM+1)-1:0]    rect_x1,
  input  logic [$clog2(MAX_DIM+1)-1:0]    rect_y0,
  input  logic [$clog2(MAX_DIM+1)-1:0]    rect_y1,
  input  logic                            active,
  output pac_pkg::pixel_out_t             res
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CH = pac_pkg::CHAN_W;

  // src + round(dst * (255 - a) / 255), saturated
  function automatic logic [CH-1:0] blend_term(
    input logic [CH-1:0] src,
    input logic [CH-1:0] a,
    input logic [CH-1:0] dst
  );
    logic [2*CH-1:0] y;
    logic [2*CH-1:0] t;
    logic [CH:0]     s;
    y = (2*CH)'(dst) * (2*CH)'(pac_pkg::CHAN_MAX - a) + (2*CH)'(pac_pkg::ROUND_BIAS);
    // floor(y / 255) for y below 255 * 256
    t = y + (2*CH)'(1) + (y >> CH);
    s = (CH+1)'(src) + (CH+1)'(t[2*CH-1:CH]);
    return s[CH] ? pac_pkg::CHAN_MAX : s[CH-1:0];
  endfunction

  logic hit;

  always_comb begin
    hit = active &&
          (DW'(column) >= rect_x0) && (DW'(column) < rect_x1) &&
          (DW'(row) >= rect_y0) && (DW'(row) < rect_y1);

    res.out_blue   = pix.view_blue;
    res.out_green  = pix.view_green;
    res.out_red    = pix.view_red;
    res.out_alpha  = pix.view_alpha;
    res.in_popup   = hit;
    res.frame_last = last;

    if (hit) begin
      if (pix.popup_alpha == pac_pkg::CHAN_MAX) begin
        res.out_blue  = pix.popup_blue;
        res.out_green = pix.popup_green;
        res.out_red   = pix.popup_red;
        res.out_alpha = pac_pkg::CHAN_MAX;
      end else if (pix.popup_alpha != '0) begin
        res.out_blue  = blend_term(pix.popup_blue, pix.popup_alpha, pix.view_blue);
        res.out_green = blend_term(pix.popup_green, pix.popup_alpha, pix.view_green);
        res.out_red   = blend_term(pix.popup_red, pix.popup_alpha, pix.view_red);
        res.out_alpha = blend_term(pix.popup_alpha, pix.popup_alpha, pix.view_alpha);
      end
    end
  end

endmodule

// File: design/popup_alpha_compositor.sv
// top level: popup over view compositor, one pixel per clock while the output is not stalled
//
//   channel | signals                               | payload
//   --------+---------------------------------------+--------------------
//   in      | in_valid, in_ready, in_data           | pac_pkg::pixel_in_t
//   out     | out_valid, out_ready, out_data        | pac_pkg::pixel_out_t
//   cfg     | cfg_write_enable, cfg_index, cfg_data | register write
//
// one transaction per clock sustained while out_ready stays high; the result passes the input
// register, the blend and the output register before it can be taken
// each channel's blend path is one 8x8 multiply, a divide-by-255 add and a saturating add
// rst is synchronous; counters, config and valid flags clear, no clearing pass
// a stalled output holds its transaction, and the input register still takes one more
`timescale 1ns / 1ps

module popup_alpha_compositor #(
  parameter int MAX_DIM = pac_pkg::MAX_DIM_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  pac_pkg::pixel_in_t              in_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output pac_pkg::pixel_out_t             out_data,
  input  logic                            cfg_write_enable,
  input  logic [pac_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pac_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int DW = $clog2(MAX_DIM + 1);
  localparam int CW = $clog2(MAX_DIM);

  logic [DW-1:0] view_w;
  logic [DW-1:0] view_h;
  logic [DW-1:0] rect_x0;
  logic [DW-1:0] rect_x1;
  logic [DW-1:0] rect_y0;
  logic [DW-1:0] rect_y1;
  logic          active;

  logic [CW-1:0] column;
  logic [CW-1:0] row;
  logic          last;

  logic               accept;
  logic               s1_advance;
  logic               s1_valid;
  pac_pkg::pixel_in_t s1_pix;
  logic [CW-1:0]      s1_column;
  logic [CW-1:0]      s1_row;
  logic               s1_last;
  pac_pkg::pixel_out_t pixel_res;

  assign s1_advance = !out_valid || out_ready;
  assign in_ready   = !s1_valid || s1_advance;
  assign accept     = in_valid && in_ready;

  pac_geom #(.MAX_DIM(MAX_DIM)) u_geom (
    .clk              (clk),
    .rst              (rst),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .view_w           (view_w),
    .view_h           (view_h),
    .rect_x0          (rect_x0),
    .rect_x1          (rect_x1),
    .rect_y0          (rect_y0),
    .rect_y1          (rect_y1),
    .active           (active)
  );

  pac_raster #(.MAX_DIM(MAX_DIM)) u_raster (
    .clk        (clk),
    .rst        (rst),
    .advance    (accept),
    .view_w     (view_w),
    .view_h     (view_h),
    .column     (column),
    .row        (row),
    .frame_last (last)
  );

  pac_pixel #(.MAX_DIM(MAX_DIM)) u_pixel (
    .pix     (s1_pix),
    .column  (s1_column),
    .row     (s1_row),
    .last    (s1_last),
    .rect_x0 (rect_x0),
    .rect_x1 (rect_x1),
    .rect_y0 (rect_y0),
    .rect_y1 (rect_y1),
    .active  (active),
    .res     (pixel_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_advance) begin
        out_valid <= s1_valid;
      end
    end
  end

  // position is taken with the pixel so it stays tied to its transaction
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= in_data;
      s1_column <= column;
      s1_row    <= row;
      s1_last   <= last;
    end
    if (s1_advance && s1_valid) begin
      out_data <= pixel_res;
    end
  end

endmodule

// File: design/pac_checker.sv
// port-level checks for the compositor, bound to the top level
`timescale 1ns / 1ps

module pac_checker (
  input logic                clk,
  input logic                rst,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input pac_pkg::pixel_out_t out_data
);

  // a stalled result holds still
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled output transaction changed");

  assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  // with no result waiting the input side must be open
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input blocked with empty output");

  // input only closes when the output is full and stalled
  assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid && !out_ready)
    else $error("input blocked without output stall");

endmodule

bind popup_alpha_compositor pac_checker u_pac_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: sim/popup_alpha_compositor_tb.sv
// self-checking testbench for the popup alpha compositor: directed rows, then random frames
`timescale 1ns / 1ps

module popup_alpha_compositor_tb;

  localparam int VIEW_LIMIT     = pac_pkg::MAX_DIM_DEFAULT;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_STALL     = 64;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;
  localparam int PHASES         = 16;
  localparam int PIXELS_PER_PHASE = 50;
  localparam int CW8            = pac_pkg::CHAN_W;

  typedef struct {
    int vw, vh, pw, ph, x, y, en;
  } cfg_set_t;

  typedef struct {
    int                  sel;
    pac_pkg::pixel_in_t  pix;
    bit                  typed;
    pac_pkg::pixel_out_t want;
  } dir_row_t;

  typedef struct packed {
    logic                typed;
    pac_pkg::pixel_out_t want;
  } result_slot_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            in_valid = 1'b0;
  logic                            in_ready;
  pac_pkg::pixel_in_t              in_data = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  pac_pkg::pixel_out_t             out_data;
  logic                            cfg_write_enable = 1'b0;
  logic [pac_pkg::CFG_INDEX_W-1:0] cfg_index = pac_pkg::REG_VIEW_WIDTH;
  logic [pac_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // predictor copy of the registers and the raster position
  logic [pac_pkg::SIZE_W-1:0]       view_w, view_h, popup_w, popup_h;
  logic signed [pac_pkg::POS_W-1:0] pos_x, pos_y;
  logic                             popup_en;
  int                               col_pos, row_pos;

  pac_pkg::pixel_out_t expected_pixels[$];
  result_slot_t        typed_results[$];
  dir_row_t            directed_rows[$];
  cfg_set_t            directed_cfgs[7];

  int tx_idle_pct, rx_idle_pct;
  int stall_requests = 0;
  int stall_seen, stall_left;
  int idle_cycles;
  int fail_count = 0;
  int pixels_in = 0;
  int results_checked = 0;
  int settings_applied = 0;

  popup_alpha_compositor u_top (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_data          (in_data),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_data         (out_data),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [CW8-1:0] blend_channel(input int src, input int alpha,
                                                   input int dst);
    int v;
    v = src + (dst * (int'(pac_pkg::CHAN_MAX) - alpha) + int'(pac_pkg::ROUND_BIAS)) /
        int'(pac_pkg::CHAN_MAX);
    return (v > int'(pac_pkg::CHAN_MAX)) ? pac_pkg::CHAN_MAX : v[CW8-1:0];
  endfunction

  function automatic int fit_origin(input int req, input int psize, input int vsize);
    int p;
    p = (req < 0) ? 0 : req;
    if (p + psize > vsize) p = vsize - psize;
    return (p < 0) ? 0 : p;
  endfunction

  // expected pixel for the current raster position; advances the position
  function automatic pac_pkg::pixel_out_t composite_pixel(input pac_pkg::pixel_in_t p);
    pac_pkg::pixel_out_t r;
    int                  w, h, x0, y0, x1, y1, a;
    bit                  view_ok;
    w = (int'(view_w) > VIEW_LIMIT) ? VIEW_LIMIT : int'(view_w);
    h = (int'(view_h) > VIEW_LIMIT) ? VIEW_LIMIT : int'(view_h);
    r.out_blue   = p.view_blue;
    r.out_green  = p.view_green;
    r.out_red    = p.view_red;
    r.out_alpha  = p.view_alpha;
    r.in_popup   = 1'b0;
    r.frame_last = 1'b0;
    view_ok = (w != 0) && (h != 0);
    if (view_ok && popup_en && popup_w != 0 && popup_h != 0) begin
      x0 = fit_origin(int'(pos_x), int'(popup_w), w);
      y0 = fit_origin(int'(pos_y), int'(popup_h), h);
      x1 = x0 + int'(popup_w);
      y1 = y0 + int'(popup_h);
      if (x1 > w) x1 = w;
      if (y1 > h) y1 = h;
      if (col_pos >= x0 && col_pos < x1 && row_pos >= y0 && row_pos < y1) begin
        r.in_popup = 1'b1;
        a = int'(p.popup_alpha);
        if (p.popup_alpha == pac_pkg::CHAN_MAX) begin
          r.out_blue  = p.popup_blue;
          r.out_green = p.popup_green;
          r.out_red   = p.popup_red;
          r.out_alpha = pac_pkg::CHAN_MAX;
        end else if (a != 0) begin
          r.out_blue  = blend_channel(int'(p.popup_blue), a, int'(p.view_blue));
          r.out_green = blend_channel(int'(p.popup_green), a, int'(p.view_green));
          r.out_red   = blend_channel(int'(p.popup_red), a, int'(p.view_red));
          r.out_alpha = blend_channel(a, a, int'(p.view_alpha));
        end
      end
    end
    // a position left out of range by a new setting still ends the row or frame
    if (view_ok) begin
      if (col_pos + 1 >= w) begin
        col_pos = 0;
        if (row_pos + 1 >= h) begin
          row_pos = 0;
          r.frame_last = 1'b1;
        end else begin
          row_pos++;
        end
      end else begin
        col_pos++;
      end
    end
    return r;
  endfunction

  // scoreboard: check outputs against the oldest expectation, predict accepted inputs
  always @(posedge clk) begin
    pac_pkg::pixel_out_t want;
    result_slot_t        slot;
    if (rst) begin
      view_w = '0; view_h = '0; popup_w = '0; popup_h = '0;
      pos_x = '0; pos_y = '0; popup_en = 1'b0;
      col_pos = 0; row_pos = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_pixels.size() == 0) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("unexpected output transaction: %p", out_data);
        end else begin
          want = expected_pixels.pop_front();
          results_checked++;
          if (out_data.out_blue !== want.out_blue || out_data.out_green !== want.out_green ||
              out_data.out_red !== want.out_red || out_data.out_alpha !== want.out_alpha ||
              out_data.in_popup !== want.in_popup ||
              out_data.frame_last !== want.frame_last) begin
            fail_count++;
            if (fail_count <= MAX_REPORTS)
              $display("mismatch on result %0d: expected bgra %0d %0d %0d %0d in %b last %b,%s",
                       results_checked, want.out_blue, want.out_green, want.out_red,
                       want.out_alpha, want.in_popup, want.frame_last,
                       $sformatf(" got bgra %0d %0d %0d %0d in %b last %b",
                                 out_data.out_blue, out_data.out_green, out_data.out_red,
                                 out_data.out_alpha, out_data.in_popup,
                                 out_data.frame_last));
          end
        end
      end
      if (in_valid && in_ready) begin
        want = composite_pixel(in_data);
        if (typed_results.size() != 0) begin
          slot = typed_results.pop_front();
          if (slot.typed) want = slot.want;
        end
        expected_pixels.push_back(want);
        pixels_in++;
      end
      if (cfg_write_enable) begin
        case (cfg_index)
          pac_pkg::REG_VIEW_WIDTH:   view_w   = cfg_data[pac_pkg::SIZE_W-1:0];
          pac_pkg::REG_VIEW_HEIGHT:  view_h   = cfg_data[pac_pkg::SIZE_W-1:0];
          pac_pkg::REG_POPUP_WIDTH:  popup_w  = cfg_data[pac_pkg::SIZE_W-1:0];
          pac_pkg::REG_POPUP_HEIGHT: popup_h  = cfg_data[pac_pkg::SIZE_W-1:0];
          pac_pkg::REG_POPUP_X:      pos_x    = cfg_data;
          pac_pkg::REG_POPUP_Y:      pos_y    = cfg_data;
          pac_pkg::REG_POPUP_ENABLE: popup_en = cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      stall_seen <= 0;
      stall_left <= 0;
    end else if (stall_seen != stall_requests) begin
      stall_seen <= stall_requests;
      stall_left <= LONG_STALL;
      out_ready  <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= WATCHDOG_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("popup_alpha_compositor test failed");
        $finish;
      end
    end
  end

  function automatic pac_pkg::pixel_in_t px(input int vb, input int vg, input int vr,
                                            input int va, input int pb, input int pg,
                                            input int pr, input int pa);
    pac_pkg::pixel_in_t p;
    p.view_blue = CW8'(vb);  p.view_green = CW8'(vg);
    p.view_red = CW8'(vr);   p.view_alpha = CW8'(va);
    p.popup_blue = CW8'(pb); p.popup_green = CW8'(pg);
    p.popup_red = CW8'(pr);  p.popup_alpha = CW8'(pa);
    return p;
  endfunction

  function automatic pac_pkg::pixel_out_t res(input int b, input int g, input int r,
                                              input int a, input bit in_rect,
                                              input bit last);
    pac_pkg::pixel_out_t o;
    o.out_blue = CW8'(b); o.out_green = CW8'(g); o.out_red = CW8'(r); o.out_alpha = CW8'(a);
    o.in_popup = in_rect; o.frame_last = last;
    return o;
  endfunction

  function automatic cfg_set_t mk_cfg(input int vw, input int vh, input int pw, input int ph,
                                      input int x, input int y, input int en);
    cfg_set_t c;
    c.vw = vw; c.vh = vh; c.pw = pw; c.ph = ph; c.x = x; c.y = y; c.en = en;
    return c;
  endfunction

  function automatic void add_row(input int sel, input pac_pkg::pixel_in_t p,
                                  input bit typed, input pac_pkg::pixel_out_t want);
    directed_rows.push_back('{sel, p, typed, want});
  endfunction

  function automatic int random_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 10) return $urandom_range(0, 8191);
    return $urandom_range(1, 10);
  endfunction

  function automatic int random_view_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 0;
    if (r < 9) return $urandom_range(VIEW_LIMIT + 1, 8191);
    if (r < 12) return VIEW_LIMIT;
    return $urandom_range(1, 8);
  endfunction

  function automatic int random_pos();
    if ($urandom_range(99) < 30) return int'($urandom_range(0, 65535)) - 32768;
    return int'($urandom_range(0, 14)) - 4;
  endfunction

  function automatic int random_chan(input int edge_pct);
    int r;
    r = $urandom_range(99);
    if (r < edge_pct) return 0;
    if (r < 2 * edge_pct) return 255;
    return $urandom_range(0, 255);
  endfunction

  function automatic pac_pkg::pixel_in_t random_pixel();
    return px(random_chan(10), random_chan(10), random_chan(10), random_chan(10),
              random_chan(10), random_chan(10), random_chan(10), random_chan(20));
  endfunction

  // wait first so the scoreboard has seen the last accepted transaction
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [pac_pkg::CFG_INDEX_W-1:0] idx, input int val);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val[pac_pkg::CFG_DATA_W-1:0];
    @(posedge clk);
  endtask

  task automatic apply_config(input cfg_set_t c);
    wait_idle();
    write_reg(pac_pkg::REG_VIEW_WIDTH, c.vw);
    write_reg(pac_pkg::REG_VIEW_HEIGHT, c.vh);
    write_reg(pac_pkg::REG_POPUP_WIDTH, c.pw);
    write_reg(pac_pkg::REG_POPUP_HEIGHT, c.ph);
    write_reg(pac_pkg::REG_POPUP_X, c.x);
    write_reg(pac_pkg::REG_POPUP_Y, c.y);
    write_reg(pac_pkg::REG_POPUP_ENABLE, c.en);
    cfg_write_enable <= 1'b0;
    settings_applied++;
  endtask

  task automatic send_pixel(input pac_pkg::pixel_in_t pix, input bit typed,
                            input pac_pkg::pixel_out_t want);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    typed_results.push_back({typed, want});
    in_valid <= 1'b1;
    in_data  <= pix;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  initial begin
    int       cur_sel;
    cfg_set_t cfg;
    tx_idle_pct = 36;
    rx_idle_pct = 81;

    // set 0 is the reset state and is never written
    directed_cfgs[0] = mk_cfg(0, 0, 0, 0, 0, 0, 0);
    directed_cfgs[1] = mk_cfg(2, 2, 2, 2, 0, 0, 1);
    directed_cfgs[2] = mk_cfg(3, 1, 3, 1, 0, 0, 0);
    // popup larger than view, origin at both extremes
    directed_cfgs[3] = mk_cfg(2, 1, 5, 5, -32768, 32767, 1);
    // view beyond the size limit, origin clamped to the right edge
    directed_cfgs[4] = mk_cfg(8191, 8191, 4, 4, 32767, 0, 1);
    // smaller view while the column is still past its end
    directed_cfgs[5] = mk_cfg(2, 2, 1, 1, 1, 1, 1);
    directed_cfgs[6] = mk_cfg(0, 5, 1, 1, 0, 0, 1);

    add_row(0, px(0, 0, 0, 0, 255, 255, 255, 255), 1, res(0, 0, 0, 0, 0, 0));
    add_row(0, px(255, 255, 255, 255, 0, 0, 0, 0), 1, res(255, 255, 255, 255, 0, 0));
    add_row(1, px(10, 20, 30, 40, 1, 2, 3, 255), 1, res(1, 2, 3, 255, 1, 0));
    add_row(1, px(10, 20, 30, 40, 1, 2, 3, 0), 1, res(10, 20, 30, 40, 1, 0));
    add_row(1, px(200, 100, 50, 255, 100, 60, 20, 128), 0, '0);
    add_row(1, px(255, 255, 255, 255, 255, 255, 255, 1), 1, res(255, 255, 255, 255, 1, 1));
    add_row(2, px(1, 2, 3, 4, 9, 9, 9, 255), 1, res(1, 2, 3, 4, 0, 0));
    add_row(2, px(5, 6, 7, 8, 9, 9, 9, 128), 1, res(5, 6, 7, 8, 0, 0));
    add_row(2, px(9, 10, 11, 12, 9, 9, 9, 1), 1, res(9, 10, 11, 12, 0, 1));
    add_row(3, px(50, 60, 70, 80, 40, 30, 20, 64), 0, '0);
    add_row(3, px(0, 0, 0, 0, 255, 128, 0, 200), 0, '0);
    add_row(4, px(11, 22, 33, 44, 55, 66, 77, 255), 0, '0);
    add_row(4, px(0, 255, 0, 255, 255, 0, 255, 100), 0, '0);
    add_row(4, px(128, 128, 128, 128, 64, 64, 64, 64), 0, '0);
    add_row(5, px(1, 1, 1, 1, 200, 200, 200, 200), 0, '0);
    add_row(5, px(2, 2, 2, 2, 100, 100, 100, 100), 0, '0);
    add_row(5, px(3, 3, 3, 3, 50, 40, 30, 60), 0, '0);
    add_row(6, px(7, 8, 9, 10, 1, 1, 1, 255), 1, res(7, 8, 9, 10, 0, 0));
    add_row(6, px(255, 0, 255, 0, 1, 1, 1, 128), 1, res(255, 0, 255, 0, 0, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    cur_sel = 0;
    foreach (directed_rows[i]) begin
      if (directed_rows[i].sel != cur_sel) begin
        cur_sel = directed_rows[i].sel;
        apply_config(directed_cfgs[cur_sel]);
      end
      send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        tx_idle_pct = 36;
        rx_idle_pct = 81;
      end else if (phase < 11) begin
        tx_idle_pct = 81;
        rx_idle_pct = 36;
      end else begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
      end
      cfg = mk_cfg(random_view_size(), random_view_size(), random_size(), random_size(),
                   random_pos(), random_pos(), ($urandom_range(99) < 85) ? 1 : 0);
      apply_config(cfg);
      // output held off while input keeps coming, so the pipeline backs up
      if (phase == 12) stall_requests++;
      repeat (PIXELS_PER_PHASE) send_pixel(random_pixel(), 1'b0, '0);
    end

    wait_idle();
    $display("%0d pixels sent, %0d results checked, %0d register settings applied",
             pixels_in, results_checked, settings_applied);
    $display("covered pass-through, clamped and clipped rectangles, blend and saturation");
    if (fail_count == 0 && expected_pixels.size() == 0) begin
      $display("popup_alpha_compositor test passed");
    end else begin
      $display("%0d failures, %0d results still outstanding", fail_count,
               expected_pixels.size());
      $display("popup_alpha_compositor test failed");
    end
    $finish;
  end

endmodule
